>>> src/bavg_pkg.sv
// Shared types and constants of the block average downsampler.
package bavg_pkg;

   localparam int PIX_W       = 8;
   localparam int SUM_W       = 16;
   localparam int BS_W        = 5;
   localparam int WIDTH_W     = 12;
   localparam int HEIGHT_W    = 16;
   localparam int AREA_W      = 10;   // block area, at most 31 * 31
   localparam int REM_W       = AREA_W;
   localparam int RECIP_SHIFT = 24;
   localparam int DIV_W       = RECIP_SHIFT + 1;
   localparam int STEP_W      = 5;
   localparam int PROD_W      = SUM_W + DIV_W;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 2;

   localparam logic [REG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

   localparam logic [BS_W-1:0]     BLOCK_SIZE_RESET   = 5'd2;
   localparam logic [WIDTH_W-1:0]  IMAGE_WIDTH_RESET  = 12'd640;
   localparam logic [HEIGHT_W-1:0] IMAGE_HEIGHT_RESET = 16'd480;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef enum logic [1:0] {
      CFG_IDLE,
      CFG_COLS,
      CFG_ROWS,
      CFG_RECIP
   } cfg_state_type;

   // effective settings and the values derived from them
   typedef struct packed {
      logic                busy;
      logic [BS_W-1:0]     bs;
      logic [WIDTH_W-1:0]  w;
      logic [HEIGHT_W-1:0] h;
      logic [WIDTH_W-1:0]  out_cols;
      logic [WIDTH_W-1:0]  col_limit;
      logic [HEIGHT_W-1:0] row_limit;
      logic [AREA_W-1:0]   area;
      logic [DIV_W-1:0]    recip;
   } derived_type;

   // one finished block on its way to the mean pipeline
   typedef struct packed {
      logic [SUM_W-1:0] blue_sum;
      logic [SUM_W-1:0] green_sum;
      logic [SUM_W-1:0] red_sum;
      logic             row_end;
      logic             frame_end;
   } block_type;

endpackage

>>> src/bavg_if.sv
// Pixel and result stream interfaces.
interface bavg_req_if;
   logic                       valid;
   logic                       ready;
   logic [bavg_pkg::PIX_W-1:0] blue_in;
   logic [bavg_pkg::PIX_W-1:0] green_in;
   logic [bavg_pkg::PIX_W-1:0] red_in;

   modport source (output valid, output blue_in, output green_in, output red_in,
                   input ready);
   modport sink (input valid, input blue_in, input green_in, input red_in,
                 output ready);
endinterface

interface bavg_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [bavg_pkg::PIX_W-1:0] blue_out;
   logic [bavg_pkg::PIX_W-1:0] green_out;
   logic [bavg_pkg::PIX_W-1:0] red_out;
   logic                       row_end;
   logic                       frame_end;

   modport source (output valid, output blue_out, output green_out, output red_out,
                   output row_end, output frame_end, input ready);
   modport sink (input valid, input blue_out, input green_out, input red_out,
                 input row_end, input frame_end, output ready);
endinterface

>>> src/bavg_cfg.sv
// Register file and the serial divider that derives block counts and the reciprocal.
module bavg_cfg #(
   parameter int MAX_WIDTH = 2048,
   parameter int MAX_BLOCK = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bavg_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bavg_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bavg_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready,
   output bavg_pkg::derived_type           dv
);

   logic [bavg_pkg::BS_W-1:0]      block_size_ff, block_size_in;
   logic [bavg_pkg::WIDTH_W-1:0]   image_width_ff, image_width_in;
   logic [bavg_pkg::HEIGHT_W-1:0]  image_height_ff, image_height_in;
   logic [bavg_pkg::REG_IDX_W-1:0] reg_idx;
   logic                           wr;

   logic [bavg_pkg::BS_W-1:0]     eff_bs;
   logic [bavg_pkg::WIDTH_W-1:0]  eff_w;
   logic [bavg_pkg::HEIGHT_W-1:0] eff_h;
   logic [bavg_pkg::AREA_W-1:0]   area;

   bavg_pkg::cfg_state_type        state_ff, state_in;
   logic [bavg_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [bavg_pkg::DIV_W-1:0]     quo_ff, quo_in;
   logic [bavg_pkg::REM_W-1:0]     rem_ff, rem_in;
   logic [bavg_pkg::DIV_W-1:0]     dividend;
   logic [bavg_pkg::AREA_W-1:0]    divisor;
   logic                           busy;
   logic [bavg_pkg::DIV_W-1:0]     cur_dvd;
   logic [bavg_pkg::REM_W-1:0]     cur_rem;
   logic [bavg_pkg::REM_W:0]       shifted;
   logic                           take;
   logic                           last_step;

   logic [bavg_pkg::WIDTH_W-1:0]  out_cols_ff;
   logic [bavg_pkg::WIDTH_W-1:0]  col_limit_ff;
   logic [bavg_pkg::HEIGHT_W-1:0] row_limit_ff;
   logic [bavg_pkg::DIV_W-1:0]    recip_ff;

   assign csr_pready = 1'b1;
   assign wr      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx = csr_paddr[bavg_pkg::CSR_ADDR_W-1:2];

   always_comb begin
      block_size_in   = block_size_ff;
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (wr) begin
         case (reg_idx)
            bavg_pkg::REG_BLOCK_SIZE: begin
               block_size_in = csr_pwdata[bavg_pkg::BS_W-1:0];
            end
            bavg_pkg::REG_IMAGE_WIDTH: begin
               image_width_in = csr_pwdata[bavg_pkg::WIDTH_W-1:0];
            end
            bavg_pkg::REG_IMAGE_HEIGHT: begin
               image_height_in = csr_pwdata[bavg_pkg::HEIGHT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff   <= bavg_pkg::BLOCK_SIZE_RESET;
         image_width_ff  <= bavg_pkg::IMAGE_WIDTH_RESET;
         image_height_ff <= bavg_pkg::IMAGE_HEIGHT_RESET;
      end else begin
         block_size_ff   <= block_size_in;
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
      end
   end

   always_comb begin
      case (reg_idx)
         bavg_pkg::REG_BLOCK_SIZE:   csr_prdata = bavg_pkg::CSR_DATA_W'(block_size_ff);
         bavg_pkg::REG_IMAGE_WIDTH:  csr_prdata = bavg_pkg::CSR_DATA_W'(image_width_ff);
         bavg_pkg::REG_IMAGE_HEIGHT: csr_prdata = bavg_pkg::CSR_DATA_W'(image_height_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // clamp out-of-range settings
   always_comb begin
      if (block_size_ff == '0) begin
         eff_bs = bavg_pkg::BS_W'(1);
      end else if (32'(block_size_ff) > MAX_BLOCK) begin
         eff_bs = bavg_pkg::BS_W'(MAX_BLOCK);
      end else begin
         eff_bs = block_size_ff;
      end
      if (image_width_ff == '0) begin
         eff_w = bavg_pkg::WIDTH_W'(1);
      end else if (32'(image_width_ff) > MAX_WIDTH) begin
         eff_w = bavg_pkg::WIDTH_W'(MAX_WIDTH);
      end else begin
         eff_w = image_width_ff;
      end
      eff_h = (image_height_ff == '0) ? bavg_pkg::HEIGHT_W'(1) : image_height_ff;
   end

   assign area = bavg_pkg::AREA_W'(eff_bs) * bavg_pkg::AREA_W'(eff_bs);

   // one restoring step per cycle; step zero takes a fresh dividend
   assign last_step = (step_ff == bavg_pkg::STEP_W'(bavg_pkg::DIV_W - 1));
   assign cur_dvd   = (step_ff == '0) ? dividend : quo_ff;
   assign cur_rem   = (step_ff == '0) ? '0 : rem_ff;
   assign shifted   = {cur_rem, cur_dvd[bavg_pkg::DIV_W-1]};
   assign take      = (shifted >= {1'b0, divisor});
   assign rem_in    = take ? bavg_pkg::REM_W'(shifted - {1'b0, divisor})
                           : shifted[bavg_pkg::REM_W-1:0];
   assign quo_in    = {cur_dvd[bavg_pkg::DIV_W-2:0], take};

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = last_step ? '0 : step_ff + bavg_pkg::STEP_W'(1);
      case (state_ff)
         bavg_pkg::CFG_IDLE: begin
            step_in = '0;
         end
         bavg_pkg::CFG_COLS: begin
            if (last_step) state_in = bavg_pkg::CFG_ROWS;
         end
         bavg_pkg::CFG_ROWS: begin
            if (last_step) state_in = bavg_pkg::CFG_RECIP;
         end
         bavg_pkg::CFG_RECIP: begin
            if (last_step) state_in = bavg_pkg::CFG_IDLE;
         end
         default: begin
            state_in = bavg_pkg::CFG_IDLE;
            step_in  = '0;
         end
      endcase
      if (wr) begin
         state_in = bavg_pkg::CFG_COLS;
         step_in  = '0;
      end
   end

   // outputs of the sequencer
   always_comb begin
      busy     = 1'b1;
      dividend = '0;
      divisor  = bavg_pkg::AREA_W'(1);
      case (state_ff)
         bavg_pkg::CFG_IDLE: begin
            busy = 1'b0;
         end
         bavg_pkg::CFG_COLS: begin
            dividend = bavg_pkg::DIV_W'(eff_w);
            divisor  = bavg_pkg::AREA_W'(eff_bs);
         end
         bavg_pkg::CFG_ROWS: begin
            dividend = bavg_pkg::DIV_W'(eff_h);
            divisor  = bavg_pkg::AREA_W'(eff_bs);
         end
         bavg_pkg::CFG_RECIP: begin
            dividend = bavg_pkg::DIV_W'(1) << bavg_pkg::RECIP_SHIFT;
            divisor  = area;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bavg_pkg::CFG_COLS;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (last_step) begin
         case (state_ff)
            bavg_pkg::CFG_COLS: begin
               out_cols_ff  <= bavg_pkg::WIDTH_W'(quo_in);
               col_limit_ff <= eff_w - bavg_pkg::WIDTH_W'(rem_in);
            end
            bavg_pkg::CFG_ROWS: begin
               row_limit_ff <= eff_h - bavg_pkg::HEIGHT_W'(rem_in);
            end
            bavg_pkg::CFG_RECIP: begin
               recip_ff <= quo_in;
            end
            default: begin
            end
         endcase
      end
   end

   assign dv.busy      = busy;
   assign dv.bs        = eff_bs;
   assign dv.w         = eff_w;
   assign dv.h         = eff_h;
   assign dv.out_cols  = out_cols_ff;
   assign dv.col_limit = col_limit_ff;
   assign dv.row_limit = row_limit_ff;
   assign dv.area      = area;
   assign dv.recip     = recip_ff;

endmodule

>>> src/bavg_front.sv
// Raster counters and the column-block accumulator line with read-modify-write.
module bavg_front #(
   parameter int MAX_WIDTH = 2048,
   parameter int MAX_BLOCK = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   bavg_req_if.sink                    req_ch,
   input  bavg_pkg::derived_type       dv,
   input  logic [bavg_pkg::QCNT_W-1:0] q_count,
   output logic                        push,
   output bavg_pkg::block_type         push_data
);

   localparam int CPW  = $clog2(MAX_WIDTH);
   localparam int BIW  = $clog2(MAX_BLOCK);
   localparam int CMPW = ((CPW > bavg_pkg::WIDTH_W) ? CPW : bavg_pkg::WIDTH_W) + 1;
   localparam int HCW  = bavg_pkg::HEIGHT_W + 1;
   localparam int BCW  = ((BIW > bavg_pkg::BS_W) ? BIW : bavg_pkg::BS_W) + 1;
   localparam int MW   = 3 * bavg_pkg::SUM_W;
   localparam int SW   = bavg_pkg::SUM_W;

   logic [CPW-1:0]                col_pos_ff, col_pos_in;
   logic [bavg_pkg::HEIGHT_W-1:0] row_pos_ff, row_pos_in;
   logic [BIW-1:0]                cib_ff, cib_in;
   logic [BIW-1:0]                rib_ff, rib_in;
   logic [CPW-1:0]                bcol_ff, bcol_in;

   logic accept, in_area, cib_last, rib_last, emit, fresh, last_col, last_row;
   logic [bavg_pkg::QCNT_W:0] committed;

   logic [MW-1:0] sums_mem [MAX_WIDTH];
   logic [MW-1:0] rd_data_ff;
   logic [MW-1:0] fwd_data_ff;
   logic [MW-1:0] old_sum;
   logic [MW-1:0] new_sum;

   logic                       s1_valid_ff;
   logic                       s1_emit_ff;
   logic                       s1_fresh_ff;
   logic                       s1_fwd_ff;
   logic                       s1_last_col_ff;
   logic                       s1_last_row_ff;
   logic [CPW-1:0]             s1_addr_ff;
   logic [bavg_pkg::PIX_W-1:0] s1_pix_ff [3];

   // room for this item's result and any result already on its way
   assign committed = {1'b0, q_count} + (bavg_pkg::QCNT_W + 1)'(s1_valid_ff & s1_emit_ff);
   assign req_ch.ready = !dv.busy &&
                         (committed < (bavg_pkg::QCNT_W + 1)'(bavg_pkg::QUEUE_DEPTH));
   assign accept = req_ch.valid & req_ch.ready;

   assign in_area  = (CMPW'(col_pos_ff) < CMPW'(dv.col_limit)) &&
                     (HCW'(row_pos_ff) < HCW'(dv.row_limit));
   assign cib_last = (BCW'(cib_ff) == BCW'(dv.bs) - BCW'(1));
   assign rib_last = (BCW'(rib_ff) == BCW'(dv.bs) - BCW'(1));
   assign emit     = in_area & cib_last & rib_last;
   assign fresh    = (cib_ff == '0) && (rib_ff == '0);
   assign last_col = (CMPW'(bcol_ff) + CMPW'(1) >= CMPW'(dv.out_cols));
   assign last_row = (HCW'(row_pos_ff) + HCW'(1) >= HCW'(dv.row_limit));

   always_comb begin
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      cib_in     = cib_ff;
      rib_in     = rib_ff;
      bcol_in    = bcol_ff;
      if (accept) begin
         if (CMPW'(col_pos_ff) + CMPW'(1) >= CMPW'(dv.w)) begin
            col_pos_in = '0;
            cib_in     = '0;
            bcol_in    = '0;
            if (HCW'(row_pos_ff) + HCW'(1) >= HCW'(dv.h)) begin
               row_pos_in = '0;
               rib_in     = '0;
            end else begin
               row_pos_in = row_pos_ff + bavg_pkg::HEIGHT_W'(1);
               rib_in     = (BCW'(rib_ff) + BCW'(1) >= BCW'(dv.bs)) ? '0
                                                                   : rib_ff + BIW'(1);
            end
         end else begin
            col_pos_in = col_pos_ff + CPW'(1);
            if (BCW'(cib_ff) + BCW'(1) >= BCW'(dv.bs)) begin
               cib_in  = '0;
               bcol_in = bcol_ff + CPW'(1);
            end else begin
               cib_in = cib_ff + BIW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff  <= '0;
         row_pos_ff  <= '0;
         cib_ff      <= '0;
         rib_ff      <= '0;
         bcol_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_pos_ff  <= col_pos_in;
         row_pos_ff  <= row_pos_in;
         cib_ff      <= cib_in;
         rib_ff      <= rib_in;
         bcol_ff     <= bcol_in;
         s1_valid_ff <= accept & in_area;
      end
   end

   // stage one payload; forward when the previous item writes our entry at our read edge
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_emit_ff     <= emit;
         s1_fresh_ff    <= fresh;
         s1_fwd_ff      <= s1_valid_ff && (s1_addr_ff == bcol_ff);
         s1_last_col_ff <= last_col;
         s1_last_row_ff <= last_row;
         s1_addr_ff     <= bcol_ff;
         s1_pix_ff[0]   <= req_ch.blue_in;
         s1_pix_ff[1]   <= req_ch.green_in;
         s1_pix_ff[2]   <= req_ch.red_in;
      end
   end

   always_comb begin
      if (s1_fresh_ff) begin
         old_sum = '0;
      end else if (s1_fwd_ff) begin
         old_sum = fwd_data_ff;
      end else begin
         old_sum = rd_data_ff;
      end
      for (int c = 0; c < 3; c++) begin
         new_sum[c*SW +: SW] = old_sum[c*SW +: SW] + SW'(s1_pix_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= sums_mem[bcol_ff];
      end
      if (s1_valid_ff) begin
         sums_mem[s1_addr_ff] <= new_sum;
         fwd_data_ff          <= new_sum;
      end
   end

   assign push                = s1_valid_ff & s1_emit_ff;
   assign push_data.blue_sum  = new_sum[0 +: SW];
   assign push_data.green_sum = new_sum[SW +: SW];
   assign push_data.red_sum   = new_sum[2*SW +: SW];
   assign push_data.row_end   = s1_last_col_ff;
   assign push_data.frame_end = s1_last_col_ff & s1_last_row_ff;

endmodule

>>> src/bavg_fifo.sv
// Short queue of finished block sums between the accumulator and the mean pipeline.
module bavg_fifo (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  bavg_pkg::block_type         push_data,
   input  logic                        pop,
   output bavg_pkg::block_type         pop_data,
   output logic                        empty,
   output logic [bavg_pkg::QCNT_W-1:0] count
);

   bavg_pkg::block_type               entry_ff [bavg_pkg::QUEUE_DEPTH];
   logic [bavg_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [bavg_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [bavg_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                              do_pop;

   assign empty  = (count_ff == '0);
   assign count  = count_ff;
   assign do_pop = pop & ~empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + bavg_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + bavg_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + bavg_pkg::QCNT_W'(push) - bavg_pkg::QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> src/bavg_back.sv
// Rounded-mean pipeline: reciprocal multiply, remainder correction, round to even.
module bavg_back (
   input  logic                  clock,
   input  logic                  reset,
   input  bavg_pkg::derived_type dv,
   input  logic                  q_empty,
   input  bavg_pkg::block_type   q_data,
   output logic                  pop,
   bavg_rsp_if.source            rsp_ch
);

   localparam int SW = bavg_pkg::SUM_W;
   localparam int RW = bavg_pkg::REM_W + 1;

   logic adv;
   logic [SW-1:0] q_sum [3];

   logic                        a_valid_ff;
   logic                        a_row_end_ff, a_frame_end_ff;
   logic [SW-1:0]               a_sum_ff  [3];
   logic [bavg_pkg::PROD_W-1:0] a_prod_ff [3];

   logic          b_valid_ff;
   logic          b_row_end_ff, b_frame_end_ff;
   logic [SW-1:0] b_q0_ff [3];
   logic [RW-1:0] b_r0_ff [3];
   logic [SW-1:0] a_q0    [3];
   logic [SW+bavg_pkg::AREA_W-1:0] a_qa [3];

   logic                       out_valid_ff;
   logic                       out_row_end_ff, out_frame_end_ff;
   logic [bavg_pkg::PIX_W-1:0] out_pix_ff [3];
   logic [bavg_pkg::PIX_W-1:0] mean [3];

   assign adv = ~out_valid_ff | rsp_ch.ready;
   assign pop = adv & ~q_empty;

   assign q_sum[0] = q_data.blue_sum;
   assign q_sum[1] = q_data.green_sum;
   assign q_sum[2] = q_data.red_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff   <= pop;
         b_valid_ff   <= a_valid_ff;
         out_valid_ff <= b_valid_ff;
      end
   end

   // stage A: sum times reciprocal of the area
   always_ff @(posedge clock) begin
      if (adv) begin
         a_row_end_ff   <= q_data.row_end;
         a_frame_end_ff <= q_data.frame_end;
         for (int c = 0; c < 3; c++) begin
            a_sum_ff[c]  <= q_sum[c];
            a_prod_ff[c] <= bavg_pkg::PROD_W'(q_sum[c]) * bavg_pkg::PROD_W'(dv.recip);
         end
      end
   end

   // stage B: estimate may be one low; keep its remainder
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         a_q0[c] = a_prod_ff[c][bavg_pkg::RECIP_SHIFT +: SW];
         a_qa[c] = (SW + bavg_pkg::AREA_W)'(a_q0[c]) * (SW + bavg_pkg::AREA_W)'(dv.area);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_row_end_ff   <= a_row_end_ff;
         b_frame_end_ff <= a_frame_end_ff;
         for (int c = 0; c < 3; c++) begin
            b_q0_ff[c] <= a_q0[c];
            b_r0_ff[c] <= RW'(a_sum_ff[c] - SW'(a_qa[c]));
         end
      end
   end

   // stage C: fix the estimate, round half to even, clip at 255
   always_comb begin
      logic [SW:0]   q1;
      logic [SW:0]   q2;
      logic [RW-1:0] r1;
      logic          up;
      for (int c = 0; c < 3; c++) begin
         if (b_r0_ff[c] >= RW'(dv.area)) begin
            q1 = (SW + 1)'(b_q0_ff[c]) + (SW + 1)'(1);
            r1 = b_r0_ff[c] - RW'(dv.area);
         end else begin
            q1 = (SW + 1)'(b_q0_ff[c]);
            r1 = b_r0_ff[c];
         end
         up = ({r1, 1'b0} > (RW + 1)'(dv.area)) ||
              (({r1, 1'b0} == (RW + 1)'(dv.area)) && q1[0]);
         q2 = q1 + (SW + 1)'(up);
         mean[c] = (q2 > (SW + 1)'(255)) ? bavg_pkg::PIX_W'(255)
                                         : q2[bavg_pkg::PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_row_end_ff   <= b_row_end_ff;
         out_frame_end_ff <= b_frame_end_ff;
         for (int c = 0; c < 3; c++) begin
            out_pix_ff[c] <= mean[c];
         end
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.blue_out  = out_pix_ff[0];
   assign rsp_ch.green_out = out_pix_ff[1];
   assign rsp_ch.red_out   = out_pix_ff[2];
   assign rsp_ch.row_end   = out_row_end_ff;
   assign rsp_ch.frame_end = out_frame_end_ff;

endmodule

>>> src/block_average_downsampler_top.sv
// Block average downsampler: top level tying registers, accumulator, queue and mean pipeline.
// Throughput: one pixel per cycle while req_ch.ready is high; the accumulator memory does one
// read and one write a cycle. A block's result passes stage one, the queue, stages A and B and
// the output register. After reset and every register write, a serial divide (three 25-step
// divisions) derives block counts and the reciprocal; req_ch.ready is low meanwhile.
// Reset is synchronous; the 2048-entry sum memory is not cleared (each block starts fresh).
module block_average_downsampler_top #(
   parameter int MAX_WIDTH = 2048,
   parameter int MAX_BLOCK = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   bavg_req_if.sink                        req_ch,
   bavg_rsp_if.source                      rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bavg_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bavg_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bavg_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   // effective settings plus divider results, with the recompute busy flag
   bavg_pkg::derived_type       dv;

   // front to queue
   logic                        push;
   bavg_pkg::block_type         push_data;

   // queue to back
   logic                        pop;
   bavg_pkg::block_type         pop_data;
   logic                        q_empty;
   logic [bavg_pkg::QCNT_W-1:0] q_count;

   // registers and the shared divider
   bavg_cfg #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_BLOCK (MAX_BLOCK)
   ) u_cfg (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .dv          (dv)
   );

   // front: raster position, accumulation per column block, completed-block detect.
   // It only takes a pixel when the queue has a slot for any result already in flight.
   bavg_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_BLOCK (MAX_BLOCK)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .dv        (dv),
      .q_count   (q_count),
      .push      (push),
      .push_data (push_data)
   );

   // decoupling queue; back pressure from rsp_ch stalls only the back until it fills
   bavg_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (q_empty),
      .count     (q_count)
   );

   // back: three-stage rounded mean ending in the output register
   bavg_back u_back (
      .clock   (clock),
      .reset   (reset),
      .dv      (dv),
      .q_empty (q_empty),
      .q_data  (pop_data),
      .pop     (pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

>>> src/bavg_checker.sv
// Port-level checks of the downsampler, bound to the top level.
module bavg_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [bavg_pkg::PIX_W-1:0] rsp_blue_out,
   input logic [bavg_pkg::PIX_W-1:0] rsp_green_out,
   input logic [bavg_pkg::PIX_W-1:0] rsp_red_out,
   input logic                       rsp_row_end,
   input logic                       rsp_frame_end,
   input logic                       csr_psel,
   input logic                       csr_penable,
   input logic                       csr_pwrite,
   input logic                       csr_pready
);

   // frame end is always also a row end
   a_frame_implies_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_row_end)
      else $error("frame_end without row_end");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_blue_out) &&
      $stable(rsp_green_out) && $stable(rsp_red_out) &&
      $stable(rsp_row_end) && $stable(rsp_frame_end))
      else $error("stalled result changed");

   // a register write starts the recompute, which blocks input
   a_write_blocks_input: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_pready |=> !req_ready)
      else $error("input accepted right after a register write");

   // reset empties the output register and starts the recompute
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("output valid or input ready after reset");

endmodule

bind block_average_downsampler_top bavg_checker u_bavg_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_blue_out  (rsp_ch.blue_out),
   .rsp_green_out (rsp_ch.green_out),
   .rsp_red_out   (rsp_ch.red_out),
   .rsp_row_end   (rsp_ch.row_end),
   .rsp_frame_end (rsp_ch.frame_end),
   .csr_psel      (csr_psel),
   .csr_penable   (csr_penable),
   .csr_pwrite    (csr_pwrite),
   .csr_pready    (csr_pready)
);

>>> tb/tb.sv
// Self-checking testbench for the block average downsampler: predictor, stimulus and checks.
`timescale 1ns / 100ps

module tb;

   localparam int MAX_W        = 2048;
   localparam int MAX_B        = 16;
   localparam int SETTLE       = 8;        // cycles past the result latency
   localparam int WIDE_PIXELS  = 48;
   localparam int RANDOM_ITEMS = 1050;

   // one expected output pixel
   typedef struct packed {
      logic [bavg_pkg::PIX_W-1:0] blue;
      logic [bavg_pkg::PIX_W-1:0] green;
      logic [bavg_pkg::PIX_W-1:0] red;
      logic                       row_end;
      logic                       frame_end;
   } block_mean_type;

   // Predicts block means from accepted pixels and checks them against the result stream.
   class block_mean_scoreboard_type;
      logic [bavg_pkg::BS_W-1:0]     block_reg  = bavg_pkg::BLOCK_SIZE_RESET;
      logic [bavg_pkg::WIDTH_W-1:0]  width_reg  = bavg_pkg::IMAGE_WIDTH_RESET;
      logic [bavg_pkg::HEIGHT_W-1:0] height_reg = bavg_pkg::IMAGE_HEIGHT_RESET;
      logic [bavg_pkg::SUM_W-1:0]    sum_b [MAX_W];
      logic [bavg_pkg::SUM_W-1:0]    sum_g [MAX_W];
      logic [bavg_pkg::SUM_W-1:0]    sum_r [MAX_W];
      int unsigned                   col_pos, row_pos, col_in_blk, row_in_blk, blk_col;
      block_mean_type                expected_means[$];
      int unsigned                   mismatch_count;

      function int unsigned eff_block();
         if (block_reg == 0) return 1;
         if (block_reg > MAX_B) return MAX_B;
         return 32'(block_reg);
      endfunction

      function int unsigned eff_width();
         if (width_reg == 0) return 1;
         if (width_reg > MAX_W) return MAX_W;
         return 32'(width_reg);
      endfunction

      function int unsigned eff_height();
         return (height_reg == 0) ? 1 : 32'(height_reg);
      endfunction

      function int unsigned frame_pixels();
         return eff_width() * eff_height();
      endfunction

      function void set_reg(logic [bavg_pkg::REG_IDX_W-1:0] idx,
                            logic [bavg_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            bavg_pkg::REG_BLOCK_SIZE:   block_reg  = value[bavg_pkg::BS_W-1:0];
            bavg_pkg::REG_IMAGE_WIDTH:  width_reg  = value[bavg_pkg::WIDTH_W-1:0];
            bavg_pkg::REG_IMAGE_HEIGHT: height_reg = value[bavg_pkg::HEIGHT_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [bavg_pkg::CSR_DATA_W-1:0] reg_value(
            logic [bavg_pkg::REG_IDX_W-1:0] idx);
         case (idx)
            bavg_pkg::REG_BLOCK_SIZE:   return bavg_pkg::CSR_DATA_W'(block_reg);
            bavg_pkg::REG_IMAGE_WIDTH:  return bavg_pkg::CSR_DATA_W'(width_reg);
            bavg_pkg::REG_IMAGE_HEIGHT: return bavg_pkg::CSR_DATA_W'(height_reg);
            default:                    return '0;
         endcase
      endfunction

      function logic [bavg_pkg::PIX_W-1:0] round_mean(logic [bavg_pkg::SUM_W-1:0] sum,
                                                       int unsigned area);
         int unsigned q, r;
         q = sum / area;
         r = sum % area;
         // nearest, ties to even
         if (2 * r > area || (2 * r == area && (q % 2) == 1)) q++;
         if (q > 255) q = 255;
         return q[bavg_pkg::PIX_W-1:0];
      endfunction

      function void take_pixel(logic [bavg_pkg::PIX_W-1:0] b, logic [bavg_pkg::PIX_W-1:0] g,
                               logic [bavg_pkg::PIX_W-1:0] r);
         int unsigned blk, wid, hgt, ocols, orows;
         logic [bavg_pkg::SUM_W-1:0] nb, ng, nr;
         bit fresh;
         block_mean_type m;
         blk   = eff_block();
         wid   = eff_width();
         hgt   = eff_height();
         ocols = wid / blk;
         orows = hgt / blk;
         if (col_pos < ocols * blk && row_pos < orows * blk && blk_col < MAX_W) begin
            fresh = (col_in_blk == 0 && row_in_blk == 0);
            nb = (fresh ? '0 : sum_b[blk_col]) + bavg_pkg::SUM_W'(b);
            ng = (fresh ? '0 : sum_g[blk_col]) + bavg_pkg::SUM_W'(g);
            nr = (fresh ? '0 : sum_r[blk_col]) + bavg_pkg::SUM_W'(r);
            sum_b[blk_col] = nb;
            sum_g[blk_col] = ng;
            sum_r[blk_col] = nr;
            if (col_in_blk == blk - 1 && row_in_blk == blk - 1) begin
               m.blue      = round_mean(nb, blk * blk);
               m.green     = round_mean(ng, blk * blk);
               m.red       = round_mean(nr, blk * blk);
               m.row_end   = (blk_col + 1 >= ocols);
               m.frame_end = m.row_end && (row_pos + 1 >= orows * blk);
               expected_means.push_back(m);
            end
         end
         // raster counters
         if (col_pos + 1 >= wid) begin
            col_pos    = 0;
            col_in_blk = 0;
            blk_col    = 0;
            if (row_pos + 1 >= hgt) begin
               row_pos    = 0;
               row_in_blk = 0;
            end else begin
               row_pos    = (row_pos + 1) & 16'hFFFF;
               row_in_blk = (row_in_blk + 1 >= blk) ? 0 : row_in_blk + 1;
            end
         end else begin
            col_pos = (col_pos + 1) & 11'h7FF;
            if (col_in_blk + 1 >= blk) begin
               col_in_blk = 0;
               blk_col    = (blk_col + 1) & 11'h7FF;
            end else begin
               col_in_blk++;
            end
         end
      endfunction

      function void check_field(string name, logic [bavg_pkg::PIX_W-1:0] want,
                                logic [bavg_pkg::PIX_W-1:0] got);
         if (want !== got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
         end
      endfunction

      function void check_result(block_mean_type got);
         block_mean_type want;
         if (expected_means.size() == 0) begin
            $display("%0t: result with no block pending: expected none actual %h", $time, got);
            mismatch_count++;
            return;
         end
         want = expected_means.pop_front();
         check_field("blue", want.blue, got.blue);
         check_field("green", want.green, got.green);
         check_field("red", want.red, got.red);
         check_field("row_end", bavg_pkg::PIX_W'(want.row_end),
                     bavg_pkg::PIX_W'(got.row_end));
         check_field("frame_end", bavg_pkg::PIX_W'(want.frame_end),
                     bavg_pkg::PIX_W'(got.frame_end));
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [bavg_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [bavg_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [bavg_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   bavg_req_if req_ch ();
   bavg_rsp_if rsp_ch ();

   block_mean_scoreboard_type sb = new();

   bit          steady;        // when set, neither side idles
   int unsigned pixels_sent;

   block_average_downsampler_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #4000000;
      $display("end of test: mismatches");
      $finish;
   end

   // Monitor: both channels are sampled at the same edge, input transfer first,
   // so the prediction never depends on scheduling order.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            sb.take_pixel(req_ch.blue_in, req_ch.green_in, req_ch.red_in);
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_result('{rsp_ch.blue_out, rsp_ch.green_out, rsp_ch.red_out,
                              rsp_ch.row_end, rsp_ch.frame_end});
      end
   end

   // Result side: ready may drop before each transfer, but never in steady stretches.
   initial begin
      int unsigned stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   function automatic logic [bavg_pkg::PIX_W-1:0] rand_chan();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         default: return bavg_pkg::PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   // One pixel transfer; enters and leaves right after a rising edge.
   task automatic push_pixel(logic [bavg_pkg::PIX_W-1:0] b, logic [bavg_pkg::PIX_W-1:0] g,
                             logic [bavg_pkg::PIX_W-1:0] r);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.blue_in  <= b;
      req_ch.green_in <= g;
      req_ch.red_in   <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pixels_sent++;
   endtask

   // Hold the sender until every pending block mean has arrived, then let the
   // pipeline settle (some pixels produce no result). The first wait lets the
   // monitor record the last transfer before the queue is looked at.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (sb.expected_means.size() != 0) @(negedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // APB write followed by a read-back of the same register.
   task automatic set_register(logic [bavg_pkg::REG_IDX_W-1:0] idx,
                               logic [bavg_pkg::CSR_DATA_W-1:0] value);
      logic [bavg_pkg::CSR_DATA_W-1:0] readback;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      // write transfer happened at this edge; go straight into the read setup
      sb.set_reg(idx, value);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      readback = csr_prdata;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== sb.reg_value(idx)) begin
         $display("%0t: register %0d read-back expected %0d actual %0d",
                  $time, idx, sb.reg_value(idx), readback);
         sb.mismatch_count++;
      end
      @(posedge clock);
   endtask

   task automatic configure(int unsigned bs_val, int unsigned w_val, int unsigned h_val);
      drain();
      set_register(bavg_pkg::REG_BLOCK_SIZE, bs_val);
      set_register(bavg_pkg::REG_IMAGE_WIDTH, w_val);
      set_register(bavg_pkg::REG_IMAGE_HEIGHT, h_val);
   endtask

   task automatic send_frames(int unsigned count);
      repeat (count * sb.frame_pixels()) begin
         push_pixel(rand_chan(), rand_chan(), rand_chan());
         // now and then hold off mid-frame until the result side has caught up
         if ($urandom_range(0, 199) == 0) drain();
      end
   endtask

   // Main stimulus.
   initial begin
      int unsigned start, sel, bs_val, eb, cols, rows, w_val, h_val, nf;
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.blue_in  <= '0;
      req_ch.green_in <= '0;
      req_ch.red_in   <= '0;
      csr_psel        <= 1'b0;
      csr_penable     <= 1'b0;
      csr_pwrite      <= 1'b0;
      csr_paddr       <= '0;
      csr_pwdata      <= '0;
      steady          = 1'b0;
      pixels_sent     = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part ---
      // 2x2 blocks on a 4x2 image: a saturated block, then a block with rounding ties
      configure(2, 4, 2);
      push_pixel(8'hFF, 8'hFF, 8'hFF);
      push_pixel(8'hFF, 8'hFF, 8'hFF);
      push_pixel(8'h00, 8'h00, 8'h00);
      push_pixel(8'h01, 8'h03, 8'h05);
      push_pixel(8'hFF, 8'hFF, 8'hFF);
      push_pixel(8'hFF, 8'hFF, 8'hFF);
      push_pixel(8'h00, 8'h00, 8'h01);
      push_pixel(8'h01, 8'h03, 8'h00);
      // zero block size, width and height all act as one
      configure(0, 0, 0);
      push_pixel(8'hA5, 8'h5A, 8'h3C);
      // image smaller than one block: no result at all
      configure(3, 2, 2);
      repeat (4) push_pixel(rand_chan(), rand_chan(), rand_chan());
      // partial right column and bottom row are dropped
      configure(2, 3, 3);
      repeat (9) push_pixel(rand_chan(), rand_chan(), rand_chan());

      // --- extreme settings ---
      // block size above the maximum clamps to 16
      configure(31, 16, 16);
      send_frames(1);
      // width above the maximum clamps to 2048: the start of one row of 1x1 blocks,
      // then a width cut puts the column counter past the bound, so the next pixel
      // is ignored and the raster wraps to the frame start
      steady = 1'b1;
      configure(1, 4095, 1);
      repeat (WIDE_PIXELS) push_pixel(rand_chan(), rand_chan(), rand_chan());
      steady = 1'b0;
      drain();
      set_register(bavg_pkg::REG_IMAGE_WIDTH, 1);
      push_pixel(rand_chan(), rand_chan(), rand_chan());
      // tallest frame, then a height cut mid-frame: the row counter is past the
      // new bound, so the next row is ignored and the frame wraps
      configure(2, 2, 65535);
      repeat (8) push_pixel(rand_chan(), rand_chan(), rand_chan());
      drain();
      set_register(bavg_pkg::REG_IMAGE_HEIGHT, 1);
      repeat (2) push_pixel(rand_chan(), rand_chan(), rand_chan());

      // --- random part: whole frames under random settings ---
      start = pixels_sent;
      while (pixels_sent < start + RANDOM_ITEMS) begin
         sel = $urandom_range(0, 9);
         if (sel < 6)       bs_val = $urandom_range(1, 4);
         else if (sel < 8)  bs_val = $urandom_range(5, 16);
         else if (sel == 8) bs_val = $urandom_range(17, 31);
         else               bs_val = 0;
         eb    = (bs_val == 0) ? 1 : ((bs_val > MAX_B) ? MAX_B : bs_val);
         cols  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, (eb <= 4) ? 5 : 1);
         rows  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, (eb <= 4) ? 4 : 1);
         w_val = eb * cols + $urandom_range(0, eb - 1);
         h_val = eb * rows + $urandom_range(0, eb - 1);
         nf    = (eb <= 4) ? $urandom_range(1, 3) : 1;
         configure(bs_val, w_val, h_val);
         steady = ($urandom_range(0, 3) == 0);
         send_frames(nf);
      end

      // --- wrap-up ---
      drain();
      steady = 1'b0;
      repeat (20) @(posedge clock);
      if (sb.mismatch_count == 0 && sb.expected_means.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

>>> block_average_downsampler_top.f
src/bavg_pkg.sv
src/bavg_if.sv
src/bavg_cfg.sv
src/bavg_front.sv
src/bavg_fifo.sv
src/bavg_back.sv
src/block_average_downsampler_top.sv
src/bavg_checker.sv
tb/tb.sv
